// ===== sv/multitap_echo_q15_core_assert.svh =====
// Assertion macros shared by the multitap echo RTL.
`ifndef MULTITAP_ECHO_Q15_CORE_ASSERT_SVH
`define MULTITAP_ECHO_Q15_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MTE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("multitap echo check failed");

// The consequent must hold in the cycle after the antecedent.
`define MTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("multitap echo check failed");

`endif

// ===== sv/mte_pkg.sv =====
// Package with types, constants and Q15 helpers for the multitap echo core.
package mte_pkg;

   // Ring sizing.
   localparam int RING_DEPTH = 4096;
   localparam int ADDR_W     = $clog2(RING_DEPTH);
   localparam int LEN_W      = ADDR_W + 1;

   // Field widths fixed by the interface.
   localparam int SAMPLE_W   = 16;
   localparam int TAP_W      = 13;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int CMP_W      = (LEN_W > TAP_W) ? LEN_W : TAP_W;
   localparam int NUM_TAPS   = 4;

   // Fixed Q15 gains.
   localparam logic signed [SAMPLE_W-1:0] DRY_GAIN   = 16'sd19661;
   localparam logic signed [SAMPLE_W-1:0] SCALE_GAIN = 16'sd12603;

   // Register reset values.
   localparam logic [TAP_W-1:0] TAP_DELAY_RST [NUM_TAPS] =
      '{13'd1323, 13'd2205, 13'd3528, 13'd3969};
   localparam logic signed [SAMPLE_W-1:0] WET_GAIN_RST [NUM_TAPS] =
      '{16'sd6554, 16'sd13107, 16'sd19661, 16'sd26214};

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TAP_DELAY_1,
      REG_TAP_DELAY_2,
      REG_TAP_DELAY_3,
      REG_TAP_DELAY_4,
      REG_WET_GAIN_1,
      REG_WET_GAIN_2,
      REG_WET_GAIN_3,
      REG_WET_GAIN_4
   } csr_reg_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRAP,
      ST_RUN
   } state_type;

   // Steps of one sample inside ST_RUN.
   localparam logic [2:0] STEP_SCALE     = 3'd0;
   localparam logic [2:0] STEP_WRITE     = 3'd1;
   localparam logic [2:0] STEP_DRY       = 3'd2;
   localparam logic [2:0] STEP_TAP_1     = 3'd3;
   localparam logic [2:0] STEP_TAP_2     = 3'd4;
   localparam logic [2:0] STEP_TAP_3     = 3'd5;
   localparam logic [2:0] STEP_TAP_4     = 3'd6;
   localparam logic [2:0] STEP_LAST      = 3'd7;

   // Operand pairs of the shared multiplier.
   typedef enum logic [1:0] {
      MUL_IN_SCALE,
      MUL_IN_DRY,
      MUL_PROD_SCALE,
      MUL_RING_GAIN
   } mul_op_type;

   // Control bundle from the sequencer to the multiply-accumulate unit.
   typedef struct packed {
      mul_op_type op;
      logic       mul_en;
      logic       clear_acc;
      logic       load_dry;
      logic       acc_en;
   } mac_ctrl_type;

   // Q15 multiply rounded toward minus infinity; the one overflow saturates.
   function automatic logic signed [SAMPLE_W-1:0] qmul(
      input logic signed [SAMPLE_W-1:0] a,
      input logic signed [SAMPLE_W-1:0] b
   );
      logic signed [2*SAMPLE_W-1:0] p;
      p = a * b;
      if (p == 32'sh4000_0000) begin
         return 16'sh7fff;
      end
      return p[2*SAMPLE_W-2:SAMPLE_W-1];
   endfunction

   // Saturating 16-bit add.
   function automatic logic signed [SAMPLE_W-1:0] sat_add(
      input logic signed [SAMPLE_W-1:0] a,
      input logic signed [SAMPLE_W-1:0] b
   );
      logic signed [SAMPLE_W:0] s;
      s = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
      if (s[SAMPLE_W] != s[SAMPLE_W-1]) begin
         return s[SAMPLE_W] ? 16'sh8000 : 16'sh7fff;
      end
      return s[SAMPLE_W-1:0];
   endfunction

endpackage

// ===== sv/mte_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mte_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/mte_wrap.sv =====
// Iterative restoring remainder unit that folds the write pointer into the ring.
module mte_wrap (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [mte_pkg::ADDR_W-1:0]    dividend,
   input  logic [mte_pkg::LEN_W-1:0]     divisor,
   output logic                          done,
   output logic [mte_pkg::ADDR_W-1:0]    remainder
);

   localparam int CNT_W = $clog2(mte_pkg::ADDR_W + 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [mte_pkg::ADDR_W-1:0]    num_ff, num_in;
   logic [mte_pkg::ADDR_W-1:0]    rem_ff, rem_in;
   logic [mte_pkg::LEN_W-1:0]     trial;

   // One quotient bit per cycle: shift in the next dividend bit and subtract.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, num_ff[mte_pkg::ADDR_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(mte_pkg::ADDR_W);
         num_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[mte_pkg::ADDR_W-2:0], 1'b0};
         if (trial >= divisor) begin
            rem_in = mte_pkg::ADDR_W'(trial - divisor);
         end else begin
            rem_in = trial[mte_pkg::ADDR_W-1:0];
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state is reset; the datapath registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== sv/mte_mac.sv =====
// Shared Q15 multiplier with tap accumulator and dry-path holding register.
module mte_mac (
   input  logic                                 clock,
   input  mte_pkg::mac_ctrl_type                ctrl,
   input  logic signed [mte_pkg::SAMPLE_W-1:0]  sample,
   input  logic signed [mte_pkg::SAMPLE_W-1:0]  gain,
   input  logic signed [mte_pkg::SAMPLE_W-1:0]  ring_data,
   output logic signed [mte_pkg::SAMPLE_W-1:0]  prod,
   output logic signed [mte_pkg::SAMPLE_W-1:0]  result
);

   logic signed [mte_pkg::SAMPLE_W-1:0] op_a, op_b;
   logic signed [mte_pkg::SAMPLE_W-1:0] prod_ff;
   logic signed [mte_pkg::SAMPLE_W-1:0] acc_ff;
   logic signed [mte_pkg::SAMPLE_W-1:0] dry_ff;

   // Operand selection for the single multiplier.
   always_comb begin
      unique case (ctrl.op)
         mte_pkg::MUL_IN_SCALE: begin
            op_a = sample;
            op_b = mte_pkg::SCALE_GAIN;
         end
         mte_pkg::MUL_IN_DRY: begin
            op_a = mte_pkg::DRY_GAIN;
            op_b = sample;
         end
         mte_pkg::MUL_PROD_SCALE: begin
            op_a = prod_ff;
            op_b = mte_pkg::SCALE_GAIN;
         end
         mte_pkg::MUL_RING_GAIN: begin
            op_a = ring_data;
            op_b = gain;
         end
         default: begin
            op_a = sample;
            op_b = mte_pkg::SCALE_GAIN;
         end
      endcase
   end

   // Product register, saturating tap sum and dry value.
   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= mte_pkg::qmul(op_a, op_b);
      end
      if (ctrl.clear_acc) begin
         acc_ff <= '0;
      end else if (ctrl.acc_en) begin
         acc_ff <= mte_pkg::sat_add(acc_ff, prod_ff);
      end
      if (ctrl.load_dry) begin
         dry_ff <= prod_ff;
      end
   end

   // Last tap product joins the sum, then the dry path is added.
   assign prod   = prod_ff;
   assign result = mte_pkg::sat_add(dry_ff, mte_pkg::sat_add(acc_ff, prod_ff));

endmodule

// ===== sv/multitap_echo_q15_core.sv =====
// Multitap echo: one shared Q15 multiplier sequenced over the ring taps.
// A new sample is taken only in idle, after the previous one has finished all 8 sequencer steps.
// The result is registered when step LAST completes; that step holds while the output is full.
// After the ring length shrinks to or below the write pointer, the remainder unit folds it first.
// Reset: control and configuration registers take their default values, then a pass over
// all ring entries zeros the ring with req_ready low; configuration writes are taken throughout.
`include "multitap_echo_q15_core_assert.svh"

module multitap_echo_q15_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [mte_pkg::SAMPLE_W-1:0]  req_sample_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [mte_pkg::SAMPLE_W-1:0]  rsp_sample_out,
   input  logic                                 csr_wr_en,
   input  logic [mte_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mte_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   mte_pkg::state_type                   state_ff, state_in;
   logic [2:0]                           step_ff, step_in;
   logic [mte_pkg::ADDR_W-1:0]           clr_addr_ff, clr_addr_in;
   logic [mte_pkg::ADDR_W-1:0]           wp_ff, wp_in;
   logic [mte_pkg::ADDR_W-1:0]           wpr_ff, wpr_in;
   logic signed [mte_pkg::SAMPLE_W-1:0]  sample_ff, sample_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [mte_pkg::SAMPLE_W-1:0]  rsp_sample_out_ff, rsp_sample_out_in;
   logic [mte_pkg::TAP_W-1:0]            tap_delay_ff [mte_pkg::NUM_TAPS];
   logic signed [mte_pkg::SAMPLE_W-1:0]  wet_gain_ff [mte_pkg::NUM_TAPS];

   logic [mte_pkg::LEN_W-1:0]            ring_len;
   logic [mte_pkg::LEN_W-1:0]            base;
   logic [mte_pkg::LEN_W-1:0]            tap_len;
   logic [mte_pkg::LEN_W-1:0]            tap_pos;
   logic [mte_pkg::ADDR_W-1:0]           next_wp;
   logic [1:0]                           rd_tap;
   logic [1:0]                           gain_tap;
   logic [mte_pkg::TAP_W-1:0]            rd_delay;

   logic                                 wrap_start;
   logic                                 wrap_done;
   logic [mte_pkg::ADDR_W-1:0]           wrap_rem;

   logic                                 ram_wr_en;
   logic [mte_pkg::ADDR_W-1:0]           ram_wr_addr;
   logic [mte_pkg::SAMPLE_W-1:0]         ram_wr_data;
   logic [mte_pkg::ADDR_W-1:0]           ram_rd_addr;
   logic [mte_pkg::SAMPLE_W-1:0]         ram_rd_data;

   mte_pkg::mac_ctrl_type                mac_ctrl;
   logic signed [mte_pkg::SAMPLE_W-1:0]  mac_prod;
   logic signed [mte_pkg::SAMPLE_W-1:0]  mac_result;
   logic                                 out_free;

   // Ring length is the fourth tap delay, held within [1, RING_DEPTH].
   always_comb begin
      if (tap_delay_ff[3] == '0) begin
         ring_len = mte_pkg::LEN_W'(1);
      end else if (mte_pkg::CMP_W'(tap_delay_ff[3]) > mte_pkg::CMP_W'(mte_pkg::RING_DEPTH)) begin
         ring_len = mte_pkg::LEN_W'(mte_pkg::RING_DEPTH);
      end else begin
         ring_len = mte_pkg::LEN_W'(tap_delay_ff[3]);
      end
   end

   // Tap read address: clamp the delay to [1, ring_len] and step back from base.
   assign base     = mte_pkg::LEN_W'(wpr_ff) + 1'b1;
   assign rd_tap   = 2'(step_ff - mte_pkg::STEP_DRY);
   assign gain_tap = 2'(step_ff - mte_pkg::STEP_TAP_1);
   assign rd_delay = tap_delay_ff[rd_tap];

   always_comb begin
      if (rd_delay == '0) begin
         tap_len = mte_pkg::LEN_W'(1);
      end else if (mte_pkg::CMP_W'(rd_delay) > mte_pkg::CMP_W'(ring_len)) begin
         tap_len = ring_len;
      end else begin
         tap_len = mte_pkg::LEN_W'(rd_delay);
      end
      tap_pos = base - tap_len + ((base < tap_len) ? ring_len : '0);
      if (tap_pos >= ring_len) begin
         ram_rd_addr = '0;
      end else begin
         ram_rd_addr = tap_pos[mte_pkg::ADDR_W-1:0];
      end
   end

   assign next_wp  = (base == ring_len) ? '0 : base[mte_pkg::ADDR_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Sequencer: next state, step and datapath controls.
   always_comb begin
      state_in          = state_ff;
      step_in           = step_ff;
      clr_addr_in       = clr_addr_ff;
      wp_in             = wp_ff;
      wpr_in            = wpr_ff;
      sample_in         = sample_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_sample_out_in = rsp_sample_out_ff;
      req_ready         = 1'b0;
      wrap_start        = 1'b0;
      ram_wr_en         = 1'b0;
      ram_wr_addr       = wpr_ff;
      ram_wr_data       = mac_prod;
      mac_ctrl          = '{op: mte_pkg::MUL_IN_SCALE, mul_en: 1'b0, clear_acc: 1'b0,
                            load_dry: 1'b0, acc_en: 1'b0};
      unique case (state_ff)
         mte_pkg::ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == mte_pkg::ADDR_W'(mte_pkg::RING_DEPTH - 1)) begin
               state_in = mte_pkg::ST_IDLE;
            end
         end
         mte_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               sample_in = req_sample_in;
               step_in   = mte_pkg::STEP_SCALE;
               if (mte_pkg::LEN_W'(wp_ff) < ring_len) begin
                  wpr_in   = wp_ff;
                  state_in = mte_pkg::ST_RUN;
               end else begin
                  wrap_start = 1'b1;
                  state_in   = mte_pkg::ST_WRAP;
               end
            end
         end
         mte_pkg::ST_WRAP: begin
            if (wrap_done) begin
               wpr_in   = wrap_rem;
               state_in = mte_pkg::ST_RUN;
            end
         end
         mte_pkg::ST_RUN: begin
            step_in = step_ff + 1'b1;
            unique case (step_ff) inside
               mte_pkg::STEP_SCALE: begin
                  mac_ctrl.op     = mte_pkg::MUL_IN_SCALE;
                  mac_ctrl.mul_en = 1'b1;
               end
               mte_pkg::STEP_WRITE: begin
                  ram_wr_en          = 1'b1;
                  mac_ctrl.op        = mte_pkg::MUL_IN_DRY;
                  mac_ctrl.mul_en    = 1'b1;
                  mac_ctrl.clear_acc = 1'b1;
               end
               mte_pkg::STEP_DRY: begin
                  mac_ctrl.op     = mte_pkg::MUL_PROD_SCALE;
                  mac_ctrl.mul_en = 1'b1;
               end
               mte_pkg::STEP_TAP_1: begin
                  mac_ctrl.op       = mte_pkg::MUL_RING_GAIN;
                  mac_ctrl.mul_en   = 1'b1;
                  mac_ctrl.load_dry = 1'b1;
               end
               mte_pkg::STEP_TAP_2, mte_pkg::STEP_TAP_3, mte_pkg::STEP_TAP_4: begin
                  mac_ctrl.op     = mte_pkg::MUL_RING_GAIN;
                  mac_ctrl.mul_en = 1'b1;
                  mac_ctrl.acc_en = 1'b1;
               end
               mte_pkg::STEP_LAST: begin
                  // Hold here until the output register can take the result.
                  step_in = step_ff;
                  if (out_free) begin
                     rsp_valid_in      = 1'b1;
                     rsp_sample_out_in = mac_result;
                     wp_in             = next_wp;
                     state_in          = mte_pkg::ST_IDLE;
                  end
               end
               default: begin
                  step_in = mte_pkg::STEP_SCALE;
               end
            endcase
         end
         default: begin
            state_in = mte_pkg::ST_IDLE;
         end
      endcase
   end

   // State register and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mte_pkg::ST_CLEAR;
         step_ff      <= mte_pkg::STEP_SCALE;
         clr_addr_ff  <= '0;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         clr_addr_ff  <= clr_addr_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      wpr_ff            <= wpr_in;
      sample_ff         <= sample_in;
      rsp_sample_out_ff <= rsp_sample_out_in;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_delay_ff <= mte_pkg::TAP_DELAY_RST;
         wet_gain_ff  <= mte_pkg::WET_GAIN_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            mte_pkg::REG_TAP_DELAY_1: tap_delay_ff[0] <= csr_wdata[mte_pkg::TAP_W-1:0];
            mte_pkg::REG_TAP_DELAY_2: tap_delay_ff[1] <= csr_wdata[mte_pkg::TAP_W-1:0];
            mte_pkg::REG_TAP_DELAY_3: tap_delay_ff[2] <= csr_wdata[mte_pkg::TAP_W-1:0];
            mte_pkg::REG_TAP_DELAY_4: tap_delay_ff[3] <= csr_wdata[mte_pkg::TAP_W-1:0];
            mte_pkg::REG_WET_GAIN_1:  wet_gain_ff[0]  <= $signed(csr_wdata);
            mte_pkg::REG_WET_GAIN_2:  wet_gain_ff[1]  <= $signed(csr_wdata);
            mte_pkg::REG_WET_GAIN_3:  wet_gain_ff[2]  <= $signed(csr_wdata);
            mte_pkg::REG_WET_GAIN_4:  wet_gain_ff[3]  <= $signed(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   // Echo ring storage.
   mte_ram #(
      .WIDTH (mte_pkg::SAMPLE_W),
      .DEPTH (mte_pkg::RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Write pointer fold after a ring length change.
   mte_wrap u_wrap (
      .clock     (clock),
      .reset     (reset),
      .start     (wrap_start),
      .dividend  (wp_ff),
      .divisor   (ring_len),
      .done      (wrap_done),
      .remainder (wrap_rem)
   );

   // Shared multiplier and accumulator.
   mte_mac u_mac (
      .clock     (clock),
      .ctrl      (mac_ctrl),
      .sample    (sample_ff),
      .gain      (wet_gain_ff[gain_tap]),
      .ring_data ($signed(ram_rd_data)),
      .prod      (mac_prod),
      .result    (mac_result)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;

   // The folded write pointer always lies inside the ring while a sample is processed.
   `MTE_ASSERT_SAME(a_wpr_in_ring, clock, reset, state_ff == mte_pkg::ST_RUN, (mte_pkg::LEN_W'(wpr_ff) < ring_len))
   // No sample is taken while the ring is being cleared.
   `MTE_ASSERT_SAME(a_no_accept_in_clear, clock, reset, state_ff == mte_pkg::ST_CLEAR, !req_ready)
   // An accepted transaction moves the sequencer out of idle.
   `MTE_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_valid && req_ready, state_ff != mte_pkg::ST_IDLE)
   // Finishing the last step always presents a result.
   `MTE_ASSERT_NEXT(a_last_step_valid, clock, reset, (state_ff == mte_pkg::ST_RUN) && (step_ff == mte_pkg::STEP_LAST) && out_free, rsp_valid && (state_ff == mte_pkg::ST_IDLE))

endmodule

// ===== dv/multitap_echo_q15_core_tb.sv =====
// Self-checking testbench for the four-tap Q15 echo core: directed table, then random phases.
`timescale 1ns / 100ps

module multitap_echo_q15_core_tb;
   import mte_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int RANDOM_PHASES  = 14;
   localparam int DIRECTED_COUNT = 27;

   typedef enum logic {
      ROW_SAMPLE,
      ROW_CSR
   } row_kind_type;

   // One row of the directed table; a typed expectation overrides the echo predictor.
   typedef struct packed {
      row_kind_type              kind;
      csr_reg_type               idx;
      logic [CSR_DATA_W-1:0]     data;
      logic                      has_exp;
      logic signed [SAMPLE_W-1:0] exp_out;
   } stim_row_type;

   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // Right after reset the ring is silent, so only the dry path is heard.
      '{ROW_SAMPLE, REG_TAP_DELAY_1, 16'h0000, 1'b1, 16'sd0},
      '{ROW_SAMPLE, REG_TAP_DELAY_1, 16'h7fff, 1'b1, 16'sd7561},
      '{ROW_SAMPLE, REG_TAP_DELAY_1, 16'h8000, 1'b1, -16'sd7562},
      '{ROW_SAMPLE, REG_TAP_DELAY_1, 16'h5555, 1'b0, 16'sd0},
      '{ROW_SAMPLE, REG_TAP_DELAY_1, 16'haaaa, 1'b0, 16'sd0},
      // A delay of one reads the sample just written; a zero delay acts as one.
      '{ROW_CSR,    REG_TAP_DELAY_1, 16'h0001, 1'b0, 16'sd0},
      '{ROW_CSR,    REG_WET_GAIN_1,  16'h7fff, 1'b0, 16'sd0},
      '{ROW_CSR,    REG_WET_GAIN_2,  16'h8000, 1'b0, 16'sd0},
      '{ROW_CSR,    REG_TAP_DELAY_2, 16'he000, 1'b0, 16'sd0},
      '{ROW_SAMPLE, REG_TAP_DELAY_1, 16'h7fff, 1'b0, 16'sd0},
      '{ROW_SAMPLE, REG_TAP_DELAY_1, 16'h8000, 1'b0, 16'sd0},
      '{ROW_SAMPLE, REG_TAP_DELAY_1, 16'h3039, 1'b0, 16'sd0},
      // Shrink the ring below the write position and clamp an oversized tap.
      '{ROW_CSR,    REG_TAP_DELAY_4, 16'h0005, 1'b0, 16'sd0},
      '{ROW_CSR,    REG_TAP_DELAY_3, 16'h1fff, 1'b0, 16'sd0},
      '{ROW_SAMPLE, REG_TAP_DELAY_1, 16'hffff, 1'b0, 16'sd0},
      '{ROW_SAMPLE, REG_TAP_DELAY_1, 16'h0001, 1'b0, 16'sd0},
      '{ROW_SAMPLE, REG_TAP_DELAY_1, 16'h7fff, 1'b0, 16'sd0},
      '{ROW_SAMPLE, REG_TAP_DELAY_1, 16'h8000, 1'b0, 16'sd0},
      // A zero ring length acts as a ring of one entry.
      '{ROW_CSR,    REG_TAP_DELAY_4, 16'h0000, 1'b0, 16'sd0},
      '{ROW_SAMPLE, REG_TAP_DELAY_1, 16'h0064, 1'b0, 16'sd0},
      '{ROW_SAMPLE, REG_TAP_DELAY_1, 16'hff9c, 1'b0, 16'sd0},
      // An oversized ring length is lowered to the full ring depth.
      '{ROW_CSR,    REG_TAP_DELAY_4, 16'h1fff, 1'b0, 16'sd0},
      '{ROW_CSR,    REG_WET_GAIN_3,  16'h8000, 1'b0, 16'sd0},
      '{ROW_CSR,    REG_WET_GAIN_4,  16'h7fff, 1'b0, 16'sd0},
      '{ROW_SAMPLE, REG_TAP_DELAY_1, 16'h7fff, 1'b0, 16'sd0},
      '{ROW_SAMPLE, REG_TAP_DELAY_1, 16'h8000, 1'b0, 16'sd0},
      '{ROW_SAMPLE, REG_TAP_DELAY_1, 16'h1234, 1'b0, 16'sd0}
   };

   logic                        clock;
   logic                        reset          = 1'b1;
   logic                        req_valid      = 1'b0;
   logic                        req_ready;
   logic signed [SAMPLE_W-1:0]  req_sample_in  = '0;
   logic                        rsp_valid;
   logic                        rsp_ready      = 1'b1;
   logic signed [SAMPLE_W-1:0]  rsp_sample_out;
   logic                        csr_wr_en      = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index      = '0;
   logic [CSR_DATA_W-1:0]       csr_wdata      = '0;

   // Shadow copy of the configuration and the echo ring.
   logic [TAP_W-1:0]            tap_len_cfg  [NUM_TAPS];
   logic signed [SAMPLE_W-1:0]  tap_gain_cfg [NUM_TAPS];
   logic signed [SAMPLE_W-1:0]  echo_store   [RING_DEPTH];
   int unsigned                 echo_wr_pos;

   logic signed [SAMPLE_W-1:0]  expected_out_q [$];
   logic signed [SAMPLE_W-1:0]  wanted_out;
   int                          fault_count    = 0;
   int                          idle_cycles    = 0;
   int                          rsp_stall_left = 0;
   bit                          sender_idle_on = 1'b1;
   bit                          rsp_stall_on   = 1'b1;

   multitap_echo_q15_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Q15 product, floored; only -1.0 * -1.0 overflows and it clips to the top.
   function automatic int q15_mul_floor(input int a, input int b);
      int prod;
      prod = a * b;
      if (prod == 32'sh4000_0000) begin
         return 32767;
      end
      return prod >>> 15;
   endfunction

   function automatic int clip16_add(input int a, input int b);
      int s;
      s = a + b;
      if (s > 32767) begin
         return 32767;
      end
      if (s < -32768) begin
         return -32768;
      end
      return s;
   endfunction

   // Writes one sample into the shadow ring and returns the mixed output sample.
   function automatic logic signed [SAMPLE_W-1:0] predict_echo_sample(
      input logic signed [SAMPLE_W-1:0] x
   );
      int unsigned ring_len;
      int unsigned wr;
      int unsigned nxt;
      int unsigned d;
      int unsigned rd;
      int          acc;
      int          dry;
      int          k;
      if (tap_len_cfg[NUM_TAPS-1] == 0) begin
         ring_len = 1;
      end else if (tap_len_cfg[NUM_TAPS-1] > RING_DEPTH) begin
         ring_len = RING_DEPTH;
      end else begin
         ring_len = tap_len_cfg[NUM_TAPS-1];
      end
      wr = echo_wr_pos % ring_len;
      echo_store[wr] = 16'(q15_mul_floor(int'(x), int'(SCALE_GAIN)));
      nxt = wr + 1;
      acc = 0;
      for (k = 0; k < NUM_TAPS; k++) begin
         d = tap_len_cfg[k];
         if (d < 1) begin
            d = 1;
         end else if (d > ring_len) begin
            d = ring_len;
         end
         rd = (nxt >= d) ? nxt - d : nxt + ring_len - d;
         if (rd >= ring_len) begin
            rd = 0;
         end
         acc = clip16_add(acc, q15_mul_floor(int'(echo_store[rd]), int'(tap_gain_cfg[k])));
      end
      echo_wr_pos = nxt % ring_len;
      dry = q15_mul_floor(q15_mul_floor(int'(DRY_GAIN), int'(x)), int'(SCALE_GAIN));
      return 16'(clip16_add(dry, acc));
   endfunction

   // Register write; the caller lowers the enable once its batch is done.
   task automatic write_csr(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      if (idx <= REG_TAP_DELAY_4) begin
         tap_len_cfg[int'(idx)] = data[TAP_W-1:0];
      end else begin
         tap_gain_cfg[int'(idx) - int'(REG_WET_GAIN_1)] = data;
      end
   endtask

   // Let every outstanding transaction return, then give the core time to settle.
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (expected_out_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Present one sample, hold it until accepted, and queue its expected output.
   task automatic send_sample(
      input logic signed [SAMPLE_W-1:0] x,
      input logic                       use_typed,
      input logic signed [SAMPLE_W-1:0] typed_out
   );
      logic signed [SAMPLE_W-1:0] predicted;
      if (sender_idle_on && $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= x;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      predicted = predict_echo_sample(x);
      expected_out_q.push_back(use_typed ? typed_out : predicted);
   endtask

   // New delays and gains for one random phase; mostly short rings so echoes land.
   task automatic write_random_setup();
      logic [TAP_W-1:0]      ring_sel;
      logic [TAP_W-1:0]      d;
      logic [CSR_DATA_W-1:0] g;
      int                    profile;
      int                    k;
      profile  = $urandom_range(0, 9);
      ring_sel = 13'($urandom_range(16, 400));
      for (k = 0; k < NUM_TAPS; k++) begin
         if (profile < 6) begin
            d = (k == NUM_TAPS - 1) ? ring_sel : 13'($urandom_range(1, ring_sel));
         end else if (profile < 8) begin
            case ($urandom_range(0, 5))
               0: d = 13'd0;
               1: d = 13'd1;
               2: d = 13'd4096;
               3: d = 13'd4097;
               4: d = 13'h1fff;
               default: d = 13'($urandom);
            endcase
         end else begin
            d = 13'($urandom);
         end
         if (profile < 6 || $urandom_range(0, 3) != 0) begin
            write_csr(csr_reg_type'(int'(REG_TAP_DELAY_1) + k), {3'($urandom), d});
         end
      end
      for (k = 0; k < NUM_TAPS; k++) begin
         case ($urandom_range(0, 7))
            0: g = 16'h7fff;
            1: g = 16'h8000;
            2: g = 16'($urandom_range(0, 8191) - 4096);
            default: g = 16'($urandom);
         endcase
         if ($urandom_range(0, 3) != 0) begin
            write_csr(csr_reg_type'(int'(REG_WET_GAIN_1) + k), g);
         end
      end
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 9)) inside
         0: begin
            case ($urandom_range(0, 4))
               0: return 16'sh7fff;
               1: return 16'sh8000;
               2: return 16'sh0000;
               3: return 16'shffff;
               default: return 16'sh0001;
            endcase
         end
         1, 2: return 16'(int'($urandom_range(0, 4000)) - 2000);
         default: return 16'($urandom);
      endcase
   endfunction

   // Result side: random bursts of stalls with rsp_ready low.
   always @(posedge clock) begin
      if (rsp_stall_left != 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_ready      <= 1'b0;
      end else if (rsp_stall_on && $urandom_range(0, 99) < 12) begin
         rsp_stall_left <= $urandom_range(0, 17);
         rsp_ready      <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each returned transaction with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_out_q.size() == 0) begin
            $error("sample_out: no result expected, actual %0d", rsp_sample_out);
            fault_count++;
         end else begin
            wanted_out = expected_out_q.pop_front();
            if (rsp_sample_out !== wanted_out) begin
               $error("sample_out: expected %0d, actual %0d", wanted_out, rsp_sample_out);
               fault_count++;
            end
         end
      end
   end

   // Watchdog on cycles in which no transaction and no register write happens.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Main sequence: reset, directed table, random phases, drain and verdict.
   initial begin
      int r;
      int p;
      int i;
      int n;
      bit prev_csr;
      foreach (tap_len_cfg[k]) begin
         tap_len_cfg[k]  = TAP_DELAY_RST[k];
         tap_gain_cfg[k] = WET_GAIN_RST[k];
      end
      foreach (echo_store[k]) begin
         echo_store[k] = '0;
      end
      echo_wr_pos = 0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      prev_csr = 1'b0;
      for (r = 0; r < DIRECTED_COUNT; r++) begin
         if (DIRECTED_ROWS[r].kind == ROW_CSR) begin
            if (!prev_csr) begin
               wait_for_idle();
            end
            write_csr(DIRECTED_ROWS[r].idx, DIRECTED_ROWS[r].data);
            prev_csr = 1'b1;
         end else begin
            if (prev_csr) begin
               csr_wr_en <= 1'b0;
            end
            send_sample(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].has_exp,
                        DIRECTED_ROWS[r].exp_out);
            prev_csr = 1'b0;
         end
      end

      // Random phases; the last one runs with no idling on either side.
      for (p = 0; p < RANDOM_PHASES; p++) begin
         wait_for_idle();
         write_random_setup();
         sender_idle_on = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
         rsp_stall_on   = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
         n = $urandom_range(90, 150);
         for (i = 0; i < n; i++) begin
            send_sample(random_sample(), 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (expected_out_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
